// ===== sv/stx_etx_crc16_deframer_macros.svh =====
// Assertion macros for the STX/ETX CRC-16 deframer checker.
`ifndef STX_ETX_CRC16_DEFRAMER_MACROS_SVH
`define STX_ETX_CRC16_DEFRAMER_MACROS_SVH

// Check a property while out of reset.
`define STXCRC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define STXCRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/stxcrc_pkg.sv =====
// Shared types and constants for the STX/ETX CRC-16 deframer.
package stxcrc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [1:0] STATUS_NONE     = 2'd0;
    localparam logic [1:0] STATUS_GOOD     = 2'd1;
    localparam logic [1:0] STATUS_CRC_ERR  = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    localparam logic [0:0] REG_START_BYTE = 1'd0;
    localparam logic [0:0] REG_END_BYTE   = 1'd1;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] byte_position;
        logic       in_frame;
        logic [1:0] frame_status;
        logic [8:0] frame_length;
    } t_result;

endpackage

// ===== sv/stxcrc_crc.sv =====
// Byte-wide CRC-16/MODBUS update (reflected polynomial).
module stxcrc_crc (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);
    import stxcrc_pkg::*;

    logic [15:0] crc_work;

    always_comb begin
        crc_work = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (crc_work[0]) begin
                crc_work = (crc_work >> 1) ^ CRC_POLY;
            end else begin
                crc_work = crc_work >> 1;
            end
        end
        o_crc = crc_work;
    end

endmodule

// ===== sv/stxcrc_core.sv =====
// Frame state machine, running CRC and result register.
module stxcrc_core #(
    parameter int MAX_FRAME = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    input  logic [7:0]          i_item_byte,
    input  stxcrc_pkg::t_cfg    i_cfg,
    input  logic                i_stall,
    output logic                o_advance,
    output logic                o_valid,
    output stxcrc_pkg::t_result o_result
);
    import stxcrc_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 1);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_BODY,
        PH_CRCH,
        PH_CRCL
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [15:0]   r_crc, n_crc;
    logic [7:0]    r_exp_high, n_exp_high;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid;
    t_result       r_res, n_res;

    logic [15:0]   crc_seed;
    logic [15:0]   crc_next;
    logic [CW-1:0] count_inc;
    logic          done;
    logic          fire;

    assign o_advance = !r_out_valid || !i_stall;
    assign fire      = i_item_valid && o_advance;

    assign crc_seed = (r_phase == PH_HUNT) ? CRC_INIT : r_crc;

    stxcrc_crc u_crc (
        .i_crc  (crc_seed),
        .i_byte (i_item_byte),
        .o_crc  (crc_next)
    );

    assign count_inc = r_count + CW'(1);

    always_comb begin
        n_phase    = r_phase;
        n_crc      = r_crc;
        n_exp_high = r_exp_high;
        n_count    = r_count;
        done       = 1'b0;
        n_res.data_byte     = i_item_byte;
        n_res.byte_position = 8'd0;
        n_res.in_frame      = 1'b0;
        n_res.frame_status  = STATUS_NONE;
        n_res.frame_length  = 9'd0;

        unique case (r_phase)
            PH_HUNT: begin
                if (i_item_byte == i_cfg.start_byte) begin
                    n_crc          = crc_next;
                    n_count        = CW'(1);
                    n_phase        = PH_BODY;
                    n_res.in_frame = 1'b1;
                end
            end
            PH_BODY: begin
                n_crc = crc_next;
                if (i_item_byte == i_cfg.end_byte) begin
                    n_phase = PH_CRCH;
                end
            end
            PH_CRCH: begin
                n_exp_high = i_item_byte;
                n_phase    = PH_CRCL;
            end
            PH_CRCL: begin
                if (r_exp_high == r_crc[15:8] && i_item_byte == r_crc[7:0]) begin
                    n_res.frame_status = STATUS_GOOD;
                end else begin
                    n_res.frame_status = STATUS_CRC_ERR;
                end
                n_res.frame_length = 9'(count_inc);
                done = 1'b1;
            end
        endcase

        if (r_phase != PH_HUNT) begin
            n_res.byte_position = 8'(r_count);
            n_res.in_frame      = 1'b1;
            n_count             = count_inc;
            // flag a frame that fills the buffer without completing
            if (!done && count_inc >= CW'(MAX_FRAME)) begin
                n_res.frame_status = STATUS_OVERFLOW;
                n_res.frame_length = 9'(MAX_FRAME);
                done = 1'b1;
            end
            if (done) begin
                n_phase    = PH_HUNT;
                n_crc      = CRC_INIT;
                n_exp_high = 8'd0;
                n_count    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_crc       <= CRC_INIT;
            r_exp_high  <= 8'd0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_phase    <= n_phase;
                r_crc      <= n_crc;
                r_exp_high <= n_exp_high;
                r_count    <= n_count;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_res;

endmodule

// ===== sv/stx_etx_crc16_deframer.sv =====
// An accepted byte passes the input register, then the result register, to its result item.
// One byte per cycle unless stalled; byte-wide CRC update and frame compare sit in one stage.
// Results can wait under stall while the next byte is taken into the input register.
// Reset (i_rst_n low, synchronous): start/end bytes return to 2 and 3, the block hunts,
// the CRC is set to 0xFFFF and both stages are emptied.
module stx_etx_crc16_deframer #(
    parameter int MAX_FRAME = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_byte_position,
    output logic       o_in_frame,
    output logic [1:0] o_frame_status,
    output logic [8:0] o_frame_length,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import stxcrc_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       advance;
    logic       in_accept;
    t_result    result;

    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_cfg.start_byte <= 8'd2;
            r_cfg.end_byte   <= 8'd3;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_START_BYTE: r_cfg.start_byte <= i_cfg_data;
                    REG_END_BYTE:   r_cfg.end_byte   <= i_cfg_data;
                endcase
            end
        end
    end

    stxcrc_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_in_valid),
        .i_item_byte  (r_in_byte),
        .i_cfg        (r_cfg),
        .i_stall      (i_stall),
        .o_advance    (advance),
        .o_valid      (o_valid),
        .o_result     (result)
    );

    assign o_data_byte     = result.data_byte;
    assign o_byte_position = result.byte_position;
    assign o_in_frame      = result.in_frame;
    assign o_frame_status  = result.frame_status;
    assign o_frame_length  = result.frame_length;

endmodule

// ===== sv/stxcrc_checker.sv =====
// Port-level checker for the STX/ETX CRC-16 deframer, bound to the top level.
`include "stx_etx_crc16_deframer_macros.svh"

module stxcrc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_rx_byte,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_data_byte,
    input logic [7:0] o_byte_position,
    input logic       o_in_frame,
    input logic [1:0] o_frame_status,
    input logic [8:0] o_frame_length
);
    import stxcrc_pkg::*;

    property p_input_held;
        i_valid && o_stall |=> i_valid && $stable(i_rx_byte);
    endproperty

    property p_hold_stalled;
        o_valid && i_stall |=> o_valid && $stable(o_data_byte) && $stable(o_frame_status);
    endproperty

    property p_outside_frame;
        o_valid && !o_in_frame |->
            o_byte_position == 8'd0 && o_frame_status == STATUS_NONE && o_frame_length == 9'd0;
    endproperty

    property p_len_only_at_end;
        o_valid && o_frame_status == STATUS_NONE |-> o_frame_length == 9'd0;
    endproperty

    `STXCRC_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_valid, "result after reset")
    `STXCRC_ASSERT(a_input_held, i_clk, i_rst_n, p_input_held, "stalled item changed")
    `STXCRC_ASSERT(a_hold_stalled, i_clk, i_rst_n, p_hold_stalled, "stalled result changed")
    `STXCRC_ASSERT(a_outside_frame, i_clk, i_rst_n, p_outside_frame, "byte outside frame carries frame data")
    `STXCRC_ASSERT(a_len_only_at_end, i_clk, i_rst_n, p_len_only_at_end, "length without frame end")

endmodule

bind stx_etx_crc16_deframer stxcrc_checker u_stxcrc_checker (.*);

// ===== sim/stx_etx_crc16_deframer_tb.sv =====
// Self-checking testbench for the STX/ETX CRC-16/MODBUS deframer.
module stx_etx_crc16_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stxcrc_pkg::*;

    localparam int FRAME_MAX   = 256;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEMS_TOTAL = 1450;

    typedef enum logic [1:0] {PH_HUNT, PH_BODY, PH_CRC_HI, PH_CRC_LO} t_rx_phase;
    typedef enum {TAIL_GOOD, TAIL_BAD_HI, TAIL_BAD_LO, TAIL_NONE} t_tail;
    typedef logic [7:0] t_byte_q[$];

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_stall     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [0:0] i_cfg_index = REG_START_BYTE;
    logic [7:0] i_cfg_data  = 8'h00;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_data_byte;
    logic [7:0] o_byte_position;
    logic       o_in_frame;
    logic [1:0] o_frame_status;
    logic [8:0] o_frame_length;

    // Predictor state
    t_rx_phase   rx_phase    = PH_HUNT;
    logic [15:0] frame_crc   = CRC_INIT;
    logic [7:0]  crc_hi_rcvd = 8'h00;
    int          frame_count = 0;
    logic [7:0]  cfg_start   = 8'h02;
    logic [7:0]  cfg_end     = 8'h03;

    t_result echo_q[$];
    t_result echo_exp;

    int error_count    = 0;
    int bytes_sent     = 0;
    int framed_items   = 0;
    int settings_count = 1;
    int status_tally[4] = '{0, 0, 0, 0};
    int cycle_count    = 0;
    bit tx_gaps_on     = 1'b1;
    int stall_left     = 0;
    int free_left      = 0;

    stx_etx_crc16_deframer #(
        .MAX_FRAME(FRAME_MAX)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_data_byte    (o_data_byte),
        .o_byte_position(o_byte_position),
        .o_in_frame     (o_in_frame),
        .o_frame_status (o_frame_status),
        .o_frame_length (o_frame_length),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("stx_etx_crc16_deframer_tb: FAIL");
        $finish;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Random body that never contains the closing byte
    function automatic t_byte_q random_body(input int n);
        t_byte_q q;
        logic [7:0] b;
        for (int k = 0; k < n; k++) begin
            b = 8'($urandom_range(0, 255));
            if (b == cfg_end) b = b ^ 8'h01;
            q.push_back(b);
        end
        return q;
    endfunction

    function automatic int tx_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Work out the result one accepted byte causes and queue it
    task automatic deframe_byte(input logic [7:0] b);
        t_result r;
        logic    done;
        r = '0;
        r.data_byte = b;
        r.frame_status = STATUS_NONE;
        done = 1'b0;
        if (rx_phase == PH_HUNT) begin
            if (b == cfg_start) begin
                frame_crc   = crc16_step(CRC_INIT, b);
                frame_count = 1;
                rx_phase    = PH_BODY;
                r.in_frame  = 1'b1;
            end
        end else begin
            r.byte_position = frame_count[7:0];
            r.in_frame = 1'b1;
            frame_count++;
            case (rx_phase)
                PH_BODY: begin
                    frame_crc = crc16_step(frame_crc, b);
                    if (b == cfg_end) rx_phase = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    crc_hi_rcvd = b;
                    rx_phase = PH_CRC_LO;
                end
                default: begin
                    r.frame_status = (crc_hi_rcvd == frame_crc[15:8] && b == frame_crc[7:0])
                                     ? STATUS_GOOD : STATUS_CRC_ERR;
                    r.frame_length = frame_count[8:0];
                    done = 1'b1;
                end
            endcase
            // a frame that fills the buffer without completing overflows
            if (!done && frame_count >= FRAME_MAX) begin
                r.frame_status = STATUS_OVERFLOW;
                r.frame_length = 9'(FRAME_MAX);
                done = 1'b1;
            end
            if (done) begin
                rx_phase    = PH_HUNT;
                frame_crc   = CRC_INIT;
                crc_hi_rcvd = 8'h00;
                frame_count = 0;
            end
        end
        if (r.in_frame) framed_items++;
        status_tally[r.frame_status]++;
        bytes_sent++;
        echo_q.push_back(r);
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_gaps_on ? tx_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        deframe_byte(b);
    endtask

    // Send start, body, end and the CRC; the CRC damaged as asked, or end and CRC left off
    task automatic send_frame(input t_byte_q body, input t_tail tail);
        logic [15:0] crc;
        logic [7:0]  flip;
        crc = crc16_step(CRC_INIT, cfg_start);
        send_byte(cfg_start);
        foreach (body[k]) begin
            crc = crc16_step(crc, body[k]);
            send_byte(body[k]);
        end
        if (tail != TAIL_NONE) begin
            crc = crc16_step(crc, cfg_end);
            send_byte(cfg_end);
            flip = 8'h01 << $urandom_range(0, 7);
            send_byte(tail == TAIL_BAD_HI ? crc[15:8] ^ flip : crc[15:8]);
            send_byte(tail == TAIL_BAD_LO ? crc[7:0] ^ flip : crc[7:0]);
        end
    endtask

    // Hold off the sender until every queued result has come back
    task automatic wait_echoes_drained();
        i_valid <= 1'b0;
        while (echo_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_frame_bytes(input logic [7:0] s, input logic [7:0] e);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_START_BYTE;
        i_cfg_data  <= s;
        @(posedge i_clk);
        cfg_start = s;
        i_cfg_index <= REG_END_BYTE;
        i_cfg_data  <= e;
        @(posedge i_clk);
        cfg_end = e;
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic check_field(input string name, input logic [8:0] expv, input logic [8:0] act);
        if (expv !== act) begin
            $error("%s: expected %0h, got %0h", name, expv, act);
            error_count++;
        end
    endtask

    // Receiver: short stalls, occasional long ones, and stall-free stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (free_left > 0) begin
            i_stall <= 1'b0;
            free_left--;
        end else begin
            i_stall <= 1'b0;
            case ($urandom_range(0, 19))
                0: free_left = $urandom_range(40, 120);
                1: stall_left = $urandom_range(15, 40);
                default: begin
                    stall_left = $urandom_range(0, 2);
                    free_left  = $urandom_range(0, 4);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (echo_q.size() == 0) begin
                $error("result with no byte pending: data_byte %0h", o_data_byte);
                error_count++;
            end else begin
                echo_exp = echo_q.pop_front();
                check_field("data_byte", 9'(echo_exp.data_byte), 9'(o_data_byte));
                check_field("byte_position", 9'(echo_exp.byte_position), 9'(o_byte_position));
                check_field("in_frame", 9'(echo_exp.in_frame), 9'(o_in_frame));
                check_field("frame_status", 9'(echo_exp.frame_status), 9'(o_frame_status));
                check_field("frame_length", echo_exp.frame_length, o_frame_length);
            end
        end
    end

    task automatic test_defaults_and_noise();
        t_byte_q body;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h03);
        send_byte(8'h55);
        body = '{8'h41};
        send_frame(body, TAIL_GOOD);
        body = {};
        send_frame(body, TAIL_BAD_LO);
        body = '{8'h10, 8'hEF};
        send_frame(body, TAIL_BAD_HI);
        wait_echoes_drained();
    endtask

    task automatic test_start_equals_end();
        t_byte_q body;
        set_frame_bytes(8'h7E, 8'h7E);
        body = '{8'h11};
        send_frame(body, TAIL_GOOD);
        body = {};
        send_frame(body, TAIL_BAD_HI);
        wait_echoes_drained();
    endtask

    task automatic test_byte_extremes();
        t_byte_q body;
        set_frame_bytes(8'h00, 8'hFF);
        body = '{8'h80, 8'h7F};
        send_frame(body, TAIL_GOOD);
        wait_echoes_drained();
        set_frame_bytes(8'hFF, 8'h00);
        body = '{8'hFF, 8'h01};
        send_frame(body, TAIL_GOOD);
        wait_echoes_drained();
    endtask

    // Move the closing byte while a frame is open
    task automatic test_cfg_mid_frame();
        logic [15:0] crc;
        set_frame_bytes(8'h02, 8'h03);
        send_byte(8'h02);
        send_byte(8'h41);
        wait_echoes_drained();
        set_frame_bytes(8'h02, 8'h41);
        crc = crc16_step(crc16_step(crc16_step(CRC_INIT, 8'h02), 8'h41), 8'h41);
        send_byte(8'h41);
        send_byte(crc[15:8]);
        send_byte(crc[7:0]);
        wait_echoes_drained();
    endtask

    task automatic test_overflow();
        set_frame_bytes(8'h02, 8'h03);
        tx_gaps_on = 1'b0;
        // body fills the buffer
        send_frame(random_body(FRAME_MAX - 1), TAIL_NONE);
        // CRC low byte lands exactly on the last slot
        send_frame(random_body(FRAME_MAX - 4), TAIL_GOOD);
        // CRC high byte fills the buffer
        send_frame(random_body(FRAME_MAX - 3), TAIL_GOOD);
        tx_gaps_on = 1'b1;
        wait_echoes_drained();
    endtask

    task automatic test_random_traffic();
        int    pick;
        int    len;
        logic [7:0] s;
        t_tail tail;
        while (bytes_sent < ITEMS_TOTAL) begin
            wait_echoes_drained();
            s = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: set_frame_bytes(8'h02, 8'h03);
                4, 5: set_frame_bytes(s, 8'($urandom_range(0, 255)));
                6: set_frame_bytes(s, s);
                7: set_frame_bytes(8'h00, 8'hFF);
                8: set_frame_bytes(8'hFF, 8'h00);
                default: set_frame_bytes(s[0] ? 8'hFF : 8'h00, s[0] ? 8'hFF : 8'h00);
            endcase
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(10, 25)) begin
                if (bytes_sent >= ITEMS_TOTAL) break;
                pick = $urandom_range(0, 99);
                len = ($urandom_range(0, 99) < 95) ? $urandom_range(0, 16)
                                                   : $urandom_range(17, 80);
                if (pick < 80) begin
                    pick = $urandom_range(0, 99);
                    tail = (pick < 70) ? TAIL_GOOD : (pick < 85) ? TAIL_BAD_HI : TAIL_BAD_LO;
                    send_frame(random_body(len), tail);
                end else if (pick < 90) begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
                end else begin
                    // truncated frame: the next frame's bytes fall into its body
                    send_frame(random_body(len % 9), TAIL_NONE);
                end
            end
        end
        wait_echoes_drained();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults_and_noise();
        test_start_equals_end();
        test_byte_extremes();
        test_cfg_mid_frame();
        test_overflow();
        test_random_traffic();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d bytes (%0d inside frames) across %0d start/end settings",
                 bytes_sent, framed_items, settings_count);
        $display("Frames ended: %0d good, %0d CRC mismatch, %0d overflow",
                 status_tally[STATUS_GOOD], status_tally[STATUS_CRC_ERR],
                 status_tally[STATUS_OVERFLOW]);
        if (error_count == 0 && echo_q.size() == 0) begin
            $display("stx_etx_crc16_deframer_tb: PASS");
        end else begin
            $display("stx_etx_crc16_deframer_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/stxcrc_pkg.sv
sv/stxcrc_crc.sv
sv/stxcrc_core.sv
sv/stx_etx_crc16_deframer.sv
sv/stxcrc_checker.sv
sim/stx_etx_crc16_deframer_tb.sv
